@@ sv/laplacian_edge_outline_3x3_macros.svh @@
// Assertion macros used by the design file.
`ifndef LAPLACIAN_EDGE_OUTLINE_3X3_MACROS_SVH
`define LAPLACIAN_EDGE_OUTLINE_3X3_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LEO_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LEO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/leo3_pkg.sv @@
package leo3_pkg;

	localparam int DEF_MAX_LINE_WIDTH = 2048;
	localparam int HEIGHT_LIMIT       = 4096;

	localparam logic [11:0] LINE_WIDTH_RST   = 12'd640;
	localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;

	localparam int          APB_AW            = 3;
	localparam logic [2:0]  ADDR_LINE_WIDTH   = 3'd0;
	localparam logic [2:0]  ADDR_FRAME_HEIGHT = 3'd4;

	typedef logic [7:0] pix_t;

	// Truncated mean of three channels. The sum is at most 765, so scaling by
	// 683/2048 gives the exact quotient by three.
	function automatic pix_t gray_of(input pix_t r, input pix_t g, input pix_t b);
		logic [9:0]  sum;
		logic [19:0] prod;
		sum  = {2'b00, r} + {2'b00, g} + {2'b00, b};
		prod = {10'd0, sum} * 20'd683;
		return prod[18:11];
	endfunction

endpackage

@@ sv/laplacian_edge_outline_3x3.sv @@
// An accepted item is held in stage one; its result is registered for the master side.
// One item per cycle unless the output stalls; the line stores are read on acceptance and
// written back as it leaves stage one, with a forwarding path for a repeated column.
// Reset: row and column counters, window, pipeline and output valids are cleared and the
// registers return to 640 and 480. Line store contents are not cleared.
`include "laplacian_edge_outline_3x3_macros.svh"

module laplacian_edge_outline_3x3
	import leo3_pkg::*;
#(
	parameter int MAX_LINE_WIDTH = DEF_MAX_LINE_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,  // red [7:0], green [15:8], blue [23:16]
	input  logic [0:0]        s_tuser,  // start_of_frame [0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,  // outline_value [7:0]
	output logic              m_tlast,
	output logic [0:0]        m_tuser,  // end_of_frame [0]
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int CW = (MAX_LINE_WIDTH > 2) ? $clog2(MAX_LINE_WIDTH) : 2;

	logic [11:0]   line_width_q;
	logic [12:0]   frame_height_q;
	logic [CW-1:0] w_last;
	logic [11:0]   h_last;

	logic [CW-1:0] col_q;
	logic [11:0]   row_q;
	logic [CW-1:0] col_in, col_eff;
	logic [11:0]   row_in, row_eff;
	logic          acc;
	pix_t          gray_in;

	pix_t          above_mem [MAX_LINE_WIDTH];
	pix_t          two_mem   [MAX_LINE_WIDTH];
	pix_t          rd_above_q, rd_two_q;

	logic          valid_s1, emit_s1, eor_s1, eof_s1;
	logic [CW-1:0] col_s1;
	pix_t          gray_s1;
	logic          fwd_q;
	pix_t          fwd_mid_q, fwd_top_q;
	logic          s1_adv;

	pix_t          win_q [6];
	pix_t          mid_cur, top_cur;
	logic [10:0]   ring;
	logic [11:0]   lap;
	pix_t          outline;

	logic          out_valid_q, out_eor_q, out_eof_q;
	pix_t          out_val_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				frame_height_q <= pwdata[12:0];
			end else begin
				line_width_q <= pwdata[11:0];
			end
		end
	end

	always_comb begin
		unique case ({paddr[APB_AW-1:2], 2'b00})
			ADDR_LINE_WIDTH:   prdata = {20'd0, line_width_q};
			ADDR_FRAME_HEIGHT: prdata = {19'd0, frame_height_q};
			default:           prdata = 32'd0;
		endcase
	end

	always_comb begin
		if (line_width_q < 12'd3) begin
			w_last = CW'(2);
		end else if (32'(line_width_q) > MAX_LINE_WIDTH) begin
			w_last = CW'(MAX_LINE_WIDTH - 1);
		end else begin
			w_last = CW'(32'(line_width_q) - 32'd1);
		end
		if (frame_height_q < 13'd3) begin
			h_last = 12'd2;
		end else if (32'(frame_height_q) > HEIGHT_LIMIT) begin
			h_last = 12'(HEIGHT_LIMIT - 1);
		end else begin
			h_last = 12'(frame_height_q - 13'd1);
		end
	end

	assign acc     = s_tvalid && s_tready;
	assign gray_in = gray_of(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
	assign col_in  = s_tuser[0] ? '0 : col_q;
	assign row_in  = s_tuser[0] ? '0 : row_q;
	assign col_eff = (col_in > w_last) ? w_last : col_in;
	assign row_eff = (row_in > h_last) ? h_last : row_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_eff == w_last) begin
				col_q <= '0;
				row_q <= (row_eff == h_last) ? 12'd0 : row_eff + 12'd1;
			end else begin
				col_q <= col_eff + CW'(1);
				row_q <= row_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_above_q <= above_mem[col_eff];
			rd_two_q   <= two_mem[col_eff];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			above_mem[col_s1] <= gray_s1;
			two_mem[col_s1]   <= mid_cur;
		end
	end

	assign mid_cur = fwd_q ? fwd_mid_q : rd_above_q;
	assign top_cur = fwd_q ? fwd_top_q : rd_two_q;

	assign s1_adv   = valid_s1 && (!emit_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_q    <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
			fwd_q    <= s1_adv && (col_s1 == col_eff);
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
			fwd_q    <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			emit_s1   <= (col_eff >= CW'(2)) && (row_eff >= 12'd2);
			eor_s1    <= (col_eff == w_last);
			eof_s1    <= (col_eff == w_last) && (row_eff == h_last);
			col_s1    <= col_eff;
			gray_s1   <= gray_in;
			fwd_mid_q <= gray_s1;
			fwd_top_q <= mid_cur;
		end
	end

	assign ring = 11'(win_q[0]) + 11'(win_q[1]) + 11'(win_q[2]) + 11'(win_q[3])
		+ 11'(win_q[5]) + 11'(top_cur) + 11'(mid_cur) + 11'(gray_s1);
	assign lap  = {1'b0, win_q[4], 3'b000} - {1'b0, ring};

	always_comb begin
		priority if (lap[11]) begin
			outline = 8'd255;
		end else if (|lap[10:8]) begin
			outline = 8'd0;
		end else begin
			outline = ~lap[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_cur;
			win_q[4] <= mid_cur;
			win_q[5] <= gray_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			out_val_q <= outline;
			out_eor_q <= eor_s1;
			out_eof_q <= eof_s1;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_val_q;
	assign m_tlast    = out_eor_q;
	assign m_tuser[0] = out_eof_q;

	`LEO_ASSERT_NEXT(a_result_loaded, s1_adv && emit_s1, out_valid_q, "result item was not loaded")
	`LEO_ASSERT_SAME(a_eof_has_eor, out_valid_q && out_eof_q, out_eor_q, "frame end without row end")
	`LEO_ASSERT_SAME(a_fwd_needs_item, fwd_q, valid_s1, "forwarding with no item in stage one")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import leo3_pkg::*;

	localparam int LINE_MAX     = DEF_MAX_LINE_WIDTH;
	localparam int RANDOM_ITEMS = 720;

	typedef struct packed {
		logic [7:0] value;
		logic       end_of_row;
		logic       end_of_frame;
	} outline_t;

	typedef enum int {PIX_RANDOM, PIX_SMOOTH, PIX_BINARY} pix_mode_e;

	// Rows of a 4x3 frame: white above, a bright centre beside a dark one, dark below.
	localparam logic [23:0] CORNER_FRAME [12] = '{
		24'hFFFFFF, 24'hFEFFFF, 24'hFFFFFF, 24'h204080,
		24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000101,
		24'h000002, 24'h000000, 24'h010100, 24'h0000FF
	};

	class outline_tracker;
		logic [11:0] width_reg;
		logic [12:0] height_reg;
		logic [7:0]  line_prev [LINE_MAX];
		logic [7:0]  line_prev2 [LINE_MAX];
		logic [7:0]  win_cols [6];
		int unsigned col_ptr;
		int unsigned row_ptr;
		outline_t    pending_outlines [$];
		int unsigned errors;

		function new();
			width_reg  = LINE_WIDTH_RST;
			height_reg = FRAME_HEIGHT_RST;
			foreach (line_prev[i]) begin
				line_prev[i]  = 8'd0;
				line_prev2[i] = 8'd0;
			end
			foreach (win_cols[i]) win_cols[i] = 8'd0;
			col_ptr = 0;
			row_ptr = 0;
			errors  = 0;
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= 10) $display("mismatch at %0t: %s", $realtime, what);
		endfunction

		function int unsigned limit(int unsigned v, int unsigned lo, int unsigned hi);
			if (v < lo) return lo;
			if (v > hi) return hi;
			return v;
		endfunction

		function int unsigned pending();
			return pending_outlines.size();
		endfunction

		function void set_register(logic [APB_AW-1:0] addr, logic [31:0] data);
			if (addr == ADDR_LINE_WIDTH) width_reg = data[11:0];
			else if (addr == ADDR_FRAME_HEIGHT) height_reg = data[12:0];
		endfunction

		function void check_register(logic [APB_AW-1:0] addr, logic [31:0] got);
			logic [31:0] want;
			want = (addr == ADDR_LINE_WIDTH) ? {20'd0, width_reg} : {19'd0, height_reg};
			if (got !== want)
				flag($sformatf("register %0d read %0h, expected %0h", addr, got, want));
		endfunction

		function void take_pixel(logic [23:0] rgb, logic sof);
			int unsigned w, h, c, r, gray, top, mid;
			int          ring, lap;
			outline_t    res;
			w    = limit(width_reg, 3, LINE_MAX);
			h    = limit(height_reg, 3, HEIGHT_LIMIT);
			gray = (int'(rgb[7:0]) + int'(rgb[15:8]) + int'(rgb[23:16])) / 3;
			if (sof) begin
				col_ptr = 0;
				row_ptr = 0;
			end
			c = (col_ptr > w - 1) ? w - 1 : col_ptr;
			r = (row_ptr > h - 1) ? h - 1 : row_ptr;
			top = line_prev2[c];
			mid = line_prev[c];
			line_prev2[c] = mid[7:0];
			line_prev[c]  = gray[7:0];
			if (c >= 2 && r >= 2) begin
				ring = int'(win_cols[0]) + int'(win_cols[1]) + int'(win_cols[2])
					+ int'(win_cols[3]) + int'(win_cols[5]) + int'(top) + int'(mid)
					+ int'(gray);
				lap = 8 * int'(win_cols[4]) - ring;
				if (lap < 0) lap = 0;
				if (lap > 255) lap = 255;
				res.value        = 8'(255 - lap);
				res.end_of_row   = (c == w - 1);
				res.end_of_frame = (c == w - 1) && (r == h - 1);
				pending_outlines.push_back(res);
			end
			win_cols[0] = win_cols[3];
			win_cols[1] = win_cols[4];
			win_cols[2] = win_cols[5];
			win_cols[3] = top[7:0];
			win_cols[4] = mid[7:0];
			win_cols[5] = gray[7:0];
			if (c == w - 1) begin
				col_ptr = 0;
				row_ptr = (r == h - 1) ? 0 : r + 1;
			end else begin
				col_ptr = c + 1;
				row_ptr = r;
			end
		endfunction

		function void check_outline(logic [7:0] value, logic eor, logic eof);
			outline_t want;
			if (pending_outlines.size() == 0) begin
				flag($sformatf("unexpected outline %0d eor %b eof %b", value, eor, eof));
				return;
			end
			want = pending_outlines.pop_front();
			if (value !== want.value || eor !== want.end_of_row || eof !== want.end_of_frame)
				flag($sformatf("outline %0d eor %b eof %b, expected %0d eor %b eof %b",
					value, eor, eof, want.value, want.end_of_row, want.end_of_frame));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [23:0]       s_tdata;
	logic [0:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [7:0]        m_tdata;
	logic              m_tlast;
	logic [0:0]        m_tuser;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	outline_tracker tracker = new();
	int unsigned    send_idle_pct;
	int unsigned    recv_idle_pct;
	int unsigned    sent_items;
	logic [7:0]     frame_base;

	laplacian_edge_outline_3x3 u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && m_tvalid && m_tready)
			tracker.check_outline(m_tdata, m_tlast, m_tuser[0]);
	end

	function automatic void apply_idle_phase(int unsigned phase);
		case (phase)
			0: begin
				send_idle_pct = 14;
				recv_idle_pct = 51;
			end
			1: begin
				send_idle_pct = 51;
				recv_idle_pct = 14;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endfunction

	function automatic logic [23:0] make_pixel(pix_mode_e mode, logic [7:0] base);
		logic [23:0] px;
		int          ch;
		case (mode)
			PIX_SMOOTH: begin
				for (int i = 0; i < 3; i++) begin
					ch = int'(base) + int'($urandom_range(24)) - 12;
					px[8*i +: 8] = (ch < 0) ? 8'd0 : (ch > 255) ? 8'd255 : 8'(ch);
				end
			end
			PIX_BINARY: px = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
			default: px = 24'($urandom);
		endcase
		return px;
	endfunction

	task automatic push_pixel(input logic [23:0] rgb, input logic sof);
		s_tvalid <= 1'b1;
		s_tdata  <= rgb;
		s_tuser  <= sof;
		do @(posedge clk); while (!s_tready);
		tracker.take_pixel(rgb, sof);
		sent_items++;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 24'($urandom);
			s_tuser  <= 1'($urandom_range(1));
			@(posedge clk);
		end
	endtask

	task automatic send_pixels(input int unsigned count, input pix_mode_e mode,
			input logic lead_sof, input int unsigned restart_pct);
		logic sof;
		for (int unsigned i = 0; i < count; i++) begin
			sof = (i == 0 && lead_sof) || ($urandom_range(99) < restart_pct);
			push_pixel(make_pixel(mode, frame_base), sof);
		end
	endtask

	task automatic wait_for_outlines(input int unsigned tail);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_register(input logic [APB_AW-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_register(addr, data);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.check_register(addr, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Bits above each field are sometimes set to show that they are ignored.
	task automatic program_size(input logic [31:0] width, input logic [31:0] height);
		wait_for_outlines(4);
		write_register(ADDR_LINE_WIDTH,
			width | ($urandom_range(1) ? ($urandom & 32'hFFFF_F000) : 32'd0));
		write_register(ADDR_FRAME_HEIGHT,
			height | ($urandom_range(1) ? ($urandom & 32'hFFFF_E000) : 32'd0));
	endtask

	initial begin
		#4_000_000;
		$display("FAIL laplacian_edge_outline_3x3");
		$finish;
	end

	initial begin
		int unsigned w, h, random_start;
		pix_mode_e   mode;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = 24'd0;
		s_tuser    = 1'b0;
		m_tready   = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = 32'd0;
		sent_items = 0;
		frame_base = 8'd128;
		apply_idle_phase(0);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_size(32'd4, 32'd3);
		foreach (CORNER_FRAME[i]) push_pixel(CORNER_FRAME[i], i == 0);
		// The second frame follows without a start mark and relies on the counters wrapping.
		send_pixels(12, PIX_SMOOTH, 1'b0, 0);

		random_start = sent_items;
		while (sent_items - random_start < RANDOM_ITEMS) begin
			apply_idle_phase(3 * (sent_items - random_start) / RANDOM_ITEMS);
			w = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(3, 8);
			h = $urandom_range(3, 6);
			program_size(w, h);
			mode       = pix_mode_e'($urandom_range(2));
			frame_base = 8'($urandom);
			case ($urandom_range(9))
				0: begin
					// Resize the frame part-way through, once two full rows are stored; the width never grows.
					send_pixels(2 * w + $urandom_range(w - 1), mode, 1'b1, 0);
					program_size($urandom_range(3, w), $urandom_range(3, 6));
					send_pixels($urandom_range(w, 3 * w), mode, 1'b0, 0);
				end
				1: send_pixels(w * h + $urandom_range(w), mode, 1'b1, 4);
				2, 3: send_pixels(2 * w * h, mode, 1'b1, 0);
				default: send_pixels(w * h, mode, 1'b1, 0);
			endcase
		end

		apply_idle_phase(2);
		program_size(32'd0, 32'd0);
		send_pixels(18, PIX_BINARY, 1'b1, 0);
		program_size(32'd0, 32'd8191);
		send_pixels(36, PIX_SMOOTH, 1'b1, 0);
		program_size(32'd3, 32'd3);
		send_pixels(18, PIX_RANDOM, 1'b1, 0);

		wait_for_outlines(8);
		if (tracker.pending() != 0)
			tracker.flag($sformatf("%0d outline items never arrived", tracker.pending()));
		if (tracker.errors == 0) begin
			$display("PASS laplacian_edge_outline_3x3");
		end else begin
			$display("FAIL laplacian_edge_outline_3x3");
		end
		$finish;
	end

endmodule
